FILE: rtl/core/hilbert_grid_tour_macros.svh
// Assertion macros for the Hilbert grid tour block.
`ifndef HILBERT_GRID_TOUR_MACROS_SVH
`define HILBERT_GRID_TOUR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HGT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hilbert_grid_tour: same-cycle check failed");
`define HGT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hilbert_grid_tour: next-cycle check failed");
`else
`define HGT_ASSERT_IMPL(label, ante, cons)
`define HGT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/hgt_pkg.sv
// Shared types and constants for the Hilbert grid tour block.
`timescale 1ns / 1ps
package hgt_pkg;

  localparam int COORD_W = 4;
  localparam int DIM_W   = 5;
  localparam logic [DIM_W-1:0] MAX_DIM = 5'd16;
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef struct packed {
    logic capture;
    logic locate;
    logic step_adv;
    logic step_last;
    logic set_invalid;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic start_in_grid;
    logic probe_hit;
    logic probe_found;
    logic active;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/hgt_if.sv
// Request and point stream interfaces of the Hilbert grid tour block.
`timescale 1ns / 1ps
interface hgt_request_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [hgt_pkg::COORD_W-1:0] start_x;
  logic [hgt_pkg::COORD_W-1:0] start_y;

  modport source (output valid, func, start_x, start_y, input ready);
  modport sink (input valid, func, start_x, start_y, output ready);
endinterface

interface hgt_point_if;
  logic                        valid;
  logic                        ready;
  logic [hgt_pkg::COORD_W-1:0] point_x;
  logic [hgt_pkg::COORD_W-1:0] point_y;
  logic                        point_valid;
  logic                        tour_last;

  modport source (output valid, point_x, point_y, point_valid, tour_last, input ready);
  modport sink (input valid, point_x, point_y, point_valid, tour_last, output ready);
endinterface

FILE: rtl/core/hgt_regs.sv
// Grid size registers behind the APB-style port, with effective limits.
`timescale 1ns / 1ps
module hgt_regs #(
  parameter int ORDER = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [hgt_pkg::DIM_W-1:0] lim_cols,
  output logic [hgt_pkg::DIM_W-1:0] lim_rows
);

  localparam int SIDE = 1 << ORDER;
  localparam int CAP  = (SIDE < int'(hgt_pkg::MAX_DIM)) ? SIDE : int'(hgt_pkg::MAX_DIM);
  localparam logic [hgt_pkg::DIM_W-1:0] CAP_V = hgt_pkg::DIM_W'(CAP);

  logic [hgt_pkg::DIM_W-1:0] grid_cols;
  logic [hgt_pkg::DIM_W-1:0] grid_rows;
  logic                      wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= hgt_pkg::DIM_RESET;
      grid_rows <= hgt_pkg::DIM_RESET;
    end else if (wr) begin
      if (paddr[2] == hgt_pkg::REG_ROWS) begin
        grid_rows <= pwdata[hgt_pkg::DIM_W-1:0];
      end else begin
        grid_cols <= pwdata[hgt_pkg::DIM_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == hgt_pkg::REG_COLS) begin
      prdata = {{(32 - hgt_pkg::DIM_W){1'b0}}, grid_cols};
    end else begin
      prdata = {{(32 - hgt_pkg::DIM_W){1'b0}}, grid_rows};
    end
  end

  assign lim_cols = (grid_cols > CAP_V) ? CAP_V : grid_cols;
  assign lim_rows = (grid_rows > CAP_V) ? CAP_V : grid_rows;

endmodule

FILE: rtl/core/hgt_ctrl.sv
// Controller state machine sequencing start, scan and result transfer.
`timescale 1ns / 1ps
module hgt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  input  logic           request_func,
  output logic           request_ready,
  input  hgt_pkg::stat_t stat,
  output hgt_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_LOCATE    = 5'b00010,
    S_STEP_ADV  = 5'b00100,
    S_STEP_LAST = 5'b01000,
    S_EMIT      = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    request_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (request_valid) begin
          if (request_func == hgt_pkg::FUNC_START) begin
            cmd.capture = 1'b1;
            state_next  = S_LOCATE;
          end else if (stat.active) begin
            state_next = S_STEP_ADV;
          end else begin
            cmd.set_invalid = 1'b1;
            state_next      = S_EMIT;
          end
        end
      end
      S_LOCATE: begin
        cmd.locate = 1'b1;
        state_next = stat.start_in_grid ? S_STEP_LAST : S_EMIT;
      end
      S_STEP_ADV: begin
        cmd.step_adv = 1'b1;
        if (stat.probe_hit) begin
          state_next = S_EMIT;
        end else if (stat.probe_found) begin
          state_next = S_STEP_LAST;
        end
      end
      S_STEP_LAST: begin
        cmd.step_last = 1'b1;
        if (stat.probe_hit || stat.probe_found) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/hgt_datapath.sv
// Curve index registers, index probe unit and output register.
`timescale 1ns / 1ps
module hgt_datapath #(
  parameter int ORDER = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hgt_pkg::cmd_t               cmd,
  output hgt_pkg::stat_t              stat,
  input  logic [hgt_pkg::COORD_W-1:0] start_x,
  input  logic [hgt_pkg::COORD_W-1:0] start_y,
  input  logic [hgt_pkg::DIM_W-1:0]   lim_cols,
  input  logic [hgt_pkg::DIM_W-1:0]   lim_rows,
  hgt_point_if.source                 point
);

  localparam int CW    = ORDER;
  localparam int IDX_W = 2 * ORDER;
  localparam int CMP_W = (CW > hgt_pkg::DIM_W) ? CW : hgt_pkg::DIM_W;

  function automatic logic [2*CW-1:0] d2xy(input logic [IDX_W-1:0] d);
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] tmp;
    logic [CW-1:0] mask;
    logic          rx;
    logic          ry;
    a = '0;
    b = '0;
    for (int i = 0; i < ORDER; i++) begin
      rx   = d[2*i+1];
      ry   = d[2*i] ^ rx;
      mask = CW'((1 << i) - 1);
      if (!ry) begin
        if (rx) begin
          a = a ^ mask;
          b = b ^ mask;
        end
        tmp = a;
        a   = b;
        b   = tmp;
      end
      a[i] = rx;
      b[i] = ry;
    end
    return {b, a};
  endfunction

  function automatic logic [IDX_W-1:0] xy2d(input logic [CW-1:0] px,
                                            input logic [CW-1:0] py);
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [CW-1:0]    tmp;
    logic [IDX_W-1:0] d;
    logic             rx;
    logic             ry;
    x = py;
    y = px;
    d = '0;
    for (int i = ORDER - 1; i >= 0; i--) begin
      rx         = x[i];
      ry         = y[i];
      d[2*i+1]   = rx;
      d[2*i]     = rx ^ ry;
      if (!ry) begin
        if (rx) begin
          x = ~x;
          y = ~y;
        end
        tmp = x;
        x   = y;
        y   = tmp;
      end
    end
    return d;
  endfunction

  logic [hgt_pkg::COORD_W-1:0] sx;
  logic [hgt_pkg::COORD_W-1:0] sy;
  logic [IDX_W-1:0]            curve_index;
  logic [IDX_W-1:0]            start_index;
  logic [IDX_W-1:0]            probe;
  logic                        active;
  logic [CW-1:0]               res_x;
  logic [CW-1:0]               res_y;
  logic                        res_valid;
  logic                        res_last;
  logic                        out_valid;
  logic [hgt_pkg::COORD_W-1:0] out_x;
  logic [hgt_pkg::COORD_W-1:0] out_y;
  logic                        out_pv;
  logic                        out_last;

  logic [CW-1:0]    probe_px;
  logic [CW-1:0]    probe_py;
  logic             probe_in;
  logic             hit;
  logic             found;
  logic             start_ok;
  logic [IDX_W-1:0] d_start;

  assign {probe_px, probe_py} = d2xy(probe);
  assign probe_in = (CMP_W'(probe_px) < CMP_W'(lim_cols)) &&
                    (CMP_W'(probe_py) < CMP_W'(lim_rows));
  assign hit      = (probe == start_index);
  assign found    = !hit && probe_in;
  assign start_ok = (hgt_pkg::DIM_W'(sx) < lim_cols) && (hgt_pkg::DIM_W'(sy) < lim_rows);
  assign d_start  = xy2d(CW'(sx), CW'(sy));

  assign stat.start_in_grid = start_ok;
  assign stat.probe_hit     = hit;
  assign stat.probe_found   = found;
  assign stat.active        = active;
  assign stat.out_free      = !out_valid || point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      curve_index <= '0;
      start_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.locate) begin
        active <= start_ok;
        if (start_ok) begin
          curve_index <= d_start;
          start_index <= d_start;
        end
      end
      if (cmd.step_adv) begin
        if (hit) begin
          active <= 1'b0;
        end else if (found) begin
          curve_index <= probe;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (point.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx <= start_x;
      sy <= start_y;
    end
    if (cmd.locate) begin
      probe     <= d_start + IDX_W'(1);
      res_x     <= CW'(sx);
      res_y     <= CW'(sy);
      res_valid <= start_ok;
      res_last  <= 1'b1;
    end
    if (cmd.step_adv) begin
      probe <= probe + IDX_W'(1);
      if (hit) begin
        res_valid <= 1'b0;
        res_last  <= 1'b1;
      end else if (found) begin
        res_x     <= probe_px;
        res_y     <= probe_py;
        res_valid <= 1'b1;
      end
    end
    if (cmd.step_last) begin
      // rewind to the index after the current point once the lookahead ends
      probe    <= (hit || found) ? curve_index + IDX_W'(1) : probe + IDX_W'(1);
      res_last <= hit;
    end
    if (cmd.set_invalid) begin
      res_valid <= 1'b0;
      res_last  <= 1'b1;
    end
    if (cmd.load_out) begin
      out_x    <= res_valid ? hgt_pkg::COORD_W'(res_x) : '0;
      out_y    <= res_valid ? hgt_pkg::COORD_W'(res_y) : '0;
      out_pv   <= res_valid;
      out_last <= res_last;
    end
  end

  assign point.valid       = out_valid;
  assign point.point_x     = out_x;
  assign point.point_y     = out_y;
  assign point.point_valid = out_pv;
  assign point.tour_last   = out_last;

endmodule

FILE: rtl/core/hilbert_grid_tour.sv
// Top level of the Hilbert grid tour block.
// Walks the in-grid points of a 2^ORDER-sided Hilbert curve one item at a time.
// A start item passes through transfer, locate, the probes and the load of the
// output register; an advance item passes through transfer, the probes and the
// load of the output register. Every probed curve index goes through the single
// index-to-point unit, one index at a time, so an item on a sparse grid probes
// more indices. An item also waits while the output register is still full. A
// finished point waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`include "hilbert_grid_tour_macros.svh"
module hilbert_grid_tour #(
  parameter int ORDER = 4
) (
  input  logic        clk,
  input  logic        rst,
  hgt_request_if.sink request,
  hgt_point_if.source point,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hgt_pkg::cmd_t             cmd;
  hgt_pkg::stat_t            stat;
  logic [hgt_pkg::DIM_W-1:0] lim_cols;
  logic [hgt_pkg::DIM_W-1:0] lim_rows;

  hgt_regs #(
    .ORDER(ORDER)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lim_cols(lim_cols),
    .lim_rows(lim_rows)
  );

  hgt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request.valid),
    .request_func (request.func),
    .request_ready(request.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  hgt_datapath #(
    .ORDER(ORDER)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .start_x (request.start_x),
    .start_y (request.start_y),
    .lim_cols(lim_cols),
    .lim_rows(lim_rows),
    .point   (point)
  );

  `HGT_ASSERT_NEXT(a_busy_after_transfer, request.valid && request.ready, !request.ready)
  `HGT_ASSERT_IMPL(a_load_into_free_slot, cmd.load_out, stat.out_free)
  `HGT_ASSERT_IMPL(a_no_point_closes, point.valid && !point.point_valid, point.tour_last && point.point_x == '0 && point.point_y == '0)

endmodule

FILE: tb/sv/hilbert_grid_tour_tb.sv
// Self-checking testbench for hilbert_grid_tour: Hilbert-order grid tours checked against a predictor.
`timescale 1ns / 1ps
module hilbert_grid_tour_tb;

  localparam int ORDER       = 4;
  localparam int SIDE        = 1 << ORDER;
  localparam int CURVE_LEN   = 1 << (2 * ORDER);
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEM_GOAL   = 1950;

  typedef struct packed {
    logic [hgt_pkg::COORD_W-1:0] x;
    logic [hgt_pkg::COORD_W-1:0] y;
    logic                        valid;
    logic                        last;
  } point_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hgt_request_if request_bus();
  hgt_point_if   point_bus();

  hilbert_grid_tour #(.ORDER(ORDER)) uut (
    .clk     (clk),
    .rst     (rst),
    .request (request_bus),
    .point   (point_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [hgt_pkg::COORD_W-1:0] curve_x [CURVE_LEN];
  logic [hgt_pkg::COORD_W-1:0] curve_y [CURVE_LEN];
  logic [7:0]                  index_of [CURVE_LEN];

  logic [hgt_pkg::DIM_W-1:0] grid_cols;
  logic [hgt_pkg::DIM_W-1:0] grid_rows;
  logic [7:0]                cur_idx;
  logic [7:0]                start_idx;
  logic                      touring;

  point_t expected_points [$];

  bit idle_on;
  int stall_left;
  int quiet_cycles;
  int mismatches;
  int items_sent;
  int points_seen;
  int tours_started;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void build_curve();
    int a, b, t, s, rx, ry, tmp;
    for (int d = 0; d < CURVE_LEN; d++) begin
      a = 0;
      b = 0;
      t = d;
      for (s = 1; s < SIDE; s = s * 2) begin
        rx = (t >> 1) & 1;
        ry = (t ^ rx) & 1;
        if (ry == 0) begin
          if (rx == 1) begin
            a = s - 1 - a;
            b = s - 1 - b;
          end
          tmp = a;
          a = b;
          b = tmp;
        end
        a += s * rx;
        b += s * ry;
        t = t >> 2;
      end
      curve_x[d] = b[hgt_pkg::COORD_W-1:0];
      curve_y[d] = a[hgt_pkg::COORD_W-1:0];
      index_of[{a[3:0], b[3:0]}] = d[7:0];
    end
  endfunction

  function automatic int grid_limit(input logic [hgt_pkg::DIM_W-1:0] v);
    return (int'(v) > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic bit in_grid(input logic [hgt_pkg::COORD_W-1:0] x,
                                 input logic [hgt_pkg::COORD_W-1:0] y);
    return int'(x) < grid_limit(grid_cols) && int'(y) < grid_limit(grid_rows);
  endfunction

  function automatic bit step_to_next(input logic [7:0] from_idx, output logic [7:0] next_idx);
    logic [7:0] idx;
    next_idx = from_idx;
    for (int k = 1; k <= CURVE_LEN; k++) begin
      idx = from_idx + 8'(k);
      if (idx == start_idx) return 1'b0;
      if (in_grid(curve_x[idx], curve_y[idx])) begin
        next_idx = idx;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_point(input logic f, input logic [hgt_pkg::COORD_W-1:0] sx,
                                        input logic [hgt_pkg::COORD_W-1:0] sy);
    point_t     p;
    logic [7:0] n;
    p = '{x: '0, y: '0, valid: 1'b0, last: 1'b1};
    if (f == hgt_pkg::FUNC_START) begin
      touring = 1'b0;
      if (in_grid(sx, sy)) begin
        start_idx = index_of[{sy, sx}];
        cur_idx   = start_idx;
        touring   = 1'b1;
        tours_started++;
      end
      if (touring)
        p = '{x: curve_x[cur_idx], y: curve_y[cur_idx], valid: 1'b1,
              last: !step_to_next(cur_idx, n)};
    end else if (!touring || !step_to_next(cur_idx, n)) begin
      touring = 1'b0;
    end else begin
      cur_idx = n;
      p = '{x: curve_x[cur_idx], y: curve_y[cur_idx], valid: 1'b1,
            last: !step_to_next(cur_idx, n)};
    end
    expected_points.push_back(p);
  endfunction

  task automatic send_request(input logic f, input logic [hgt_pkg::COORD_W-1:0] sx,
                              input logic [hgt_pkg::COORD_W-1:0] sy);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      request_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    request_bus.valid   <= 1'b1;
    request_bus.func    <= f;
    request_bus.start_x <= sx;
    request_bus.start_y <= sy;
    @(posedge clk);
    while (!request_bus.ready) @(posedge clk);
    items_sent++;
    predict_point(f, sx, sy);
  endtask

  task automatic settle_points();
    request_bus.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_grid_reg(input logic which, input logic [hgt_pkg::DIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == hgt_pkg::REG_COLS) grid_cols = value;
    else grid_rows = value;
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [hgt_pkg::DIM_W-1:0] pick_dim();
    return ($urandom_range(0, 7) == 0) ? hgt_pkg::DIM_W'($urandom_range(0, 31))
                                       : hgt_pkg::DIM_W'($urandom_range(6, 31));
  endfunction

  task automatic test_idle_advance();
    settle_points();
    send_request(hgt_pkg::FUNC_ADVANCE, 4'd15, 4'd15);
  endtask

  task automatic test_full_grid_corners();
    settle_points();
    send_request(hgt_pkg::FUNC_START, 4'd0, 4'd0);
    repeat (2) send_request(hgt_pkg::FUNC_ADVANCE, 4'd0, 4'd0);
    send_request(hgt_pkg::FUNC_START, 4'd15, 4'd15);
    send_request(hgt_pkg::FUNC_ADVANCE, 4'd15, 4'd0);
  endtask

  task automatic test_outside_start();
    settle_points();
    write_grid_reg(hgt_pkg::REG_COLS, 5'd5);
    write_grid_reg(hgt_pkg::REG_ROWS, 5'd3);
    send_request(hgt_pkg::FUNC_START, 4'd5, 4'd0);
    send_request(hgt_pkg::FUNC_START, 4'd0, 4'd3);
    send_request(hgt_pkg::FUNC_ADVANCE, 4'd0, 4'd0);
  endtask

  task automatic test_single_point();
    settle_points();
    write_grid_reg(hgt_pkg::REG_COLS, 5'd1);
    write_grid_reg(hgt_pkg::REG_ROWS, 5'd1);
    send_request(hgt_pkg::FUNC_START, 4'd0, 4'd0);
    send_request(hgt_pkg::FUNC_ADVANCE, 4'd0, 4'd0);
  endtask

  task automatic test_empty_and_oversized();
    settle_points();
    write_grid_reg(hgt_pkg::REG_COLS, 5'd0);
    send_request(hgt_pkg::FUNC_START, 4'd0, 4'd0);
    settle_points();
    write_grid_reg(hgt_pkg::REG_COLS, 5'd31);
    write_grid_reg(hgt_pkg::REG_ROWS, 5'd17);
    send_request(hgt_pkg::FUNC_START, 4'd15, 4'd15);
    send_request(hgt_pkg::FUNC_ADVANCE, 4'd0, 4'd0);
  endtask

  task automatic test_tour_wrap_end();
    settle_points();
    write_grid_reg(hgt_pkg::REG_COLS, 5'd2);
    write_grid_reg(hgt_pkg::REG_ROWS, 5'd2);
    send_request(hgt_pkg::FUNC_START, 4'd1, 4'd1);
    repeat (4) send_request(hgt_pkg::FUNC_ADVANCE, 4'd0, 4'd0);
  endtask

  task automatic test_grid_change();
    settle_points();
    write_grid_reg(hgt_pkg::REG_COLS, 5'd4);
    write_grid_reg(hgt_pkg::REG_ROWS, 5'd4);
    send_request(hgt_pkg::FUNC_START, 4'd1, 4'd0);
    repeat (2) send_request(hgt_pkg::FUNC_ADVANCE, 4'd0, 4'd0);
    settle_points();
    write_grid_reg(hgt_pkg::REG_COLS, 5'd1);
    repeat (3) send_request(hgt_pkg::FUNC_ADVANCE, 4'd0, 4'd0);
  endtask

  task automatic test_random_tours(input int goal);
    int n, lc, lr, kind;
    logic [hgt_pkg::COORD_W-1:0] sx, sy;
    while (items_sent < goal) begin
      settle_points();
      if ($urandom_range(0, 3) != 0) write_grid_reg(hgt_pkg::REG_COLS, pick_dim());
      if ($urandom_range(0, 3) != 0) write_grid_reg(hgt_pkg::REG_ROWS, pick_dim());
      lc = grid_limit(grid_cols);
      lr = grid_limit(grid_rows);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(5, 20))
          send_request(1'($urandom_range(0, 1)), 4'($urandom), 4'($urandom));
      end else if (kind == 1) begin
        repeat ($urandom_range(5, 30))
          send_request(hgt_pkg::FUNC_ADVANCE, 4'($urandom), 4'($urandom));
      end else begin
        if (lc == 0 || lr == 0 || $urandom_range(0, 7) == 0) begin
          sx = 4'($urandom);
          sy = 4'($urandom);
        end else begin
          sx = 4'($urandom_range(0, lc - 1));
          sy = 4'($urandom_range(0, lr - 1));
        end
        send_request(hgt_pkg::FUNC_START, sx, sy);
        n = lc * lr;
        if ($urandom_range(0, 1) == 1) n = n + $urandom_range(0, 2);
        else n = $urandom_range(1, n + 1);
        if (items_sent + n > goal) n = (goal > items_sent) ? goal - items_sent : 0;
        repeat (n) send_request(hgt_pkg::FUNC_ADVANCE, 4'($urandom), 4'($urandom));
      end
    end
  endtask

  task automatic test_steady_stream(input int goal);
    settle_points();
    idle_on = 1'b0;
    write_grid_reg(hgt_pkg::REG_COLS, 5'd16);
    write_grid_reg(hgt_pkg::REG_ROWS, 5'd16);
    send_request(hgt_pkg::FUNC_START, 4'($urandom), 4'($urandom));
    while (items_sent < goal)
      send_request(hgt_pkg::FUNC_ADVANCE, 4'($urandom), 4'($urandom));
    settle_points();
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      point_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      point_bus.ready <= 1'b0;
    end else begin
      point_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_t got;
    point_t want;
    if (!rst && point_bus.valid && point_bus.ready) begin
      got = '{x: point_bus.point_x, y: point_bus.point_y,
              valid: point_bus.point_valid, last: point_bus.tour_last};
      if (got.valid) points_seen++;
      if (expected_points.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected point transfer: x=%0d y=%0d valid=%0b last=%0b",
                 $time, got.x, got.y, got.valid, got.last);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: point mismatch: expected x=%0d y=%0d valid=%0b last=%0b, actual x=%0d y=%0d valid=%0b last=%0b",
                   $time, want.x, want.y, want.valid, want.last,
                   got.x, got.y, got.valid, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((request_bus.valid && request_bus.ready) || (point_bus.valid && point_bus.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: timeout, %0d points still expected", $time, expected_points.size());
      $display("hilbert_grid_tour_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    request_bus.valid   = 1'b0;
    request_bus.func    = hgt_pkg::FUNC_START;
    request_bus.start_x = '0;
    request_bus.start_y = '0;
    point_bus.ready     = 1'b0;
    stall_left          = 0;
    quiet_cycles        = 0;
    mismatches          = 0;
    items_sent          = 0;
    points_seen         = 0;
    tours_started       = 0;
    reg_writes          = 0;
    idle_on             = 1'b1;
    grid_cols           = hgt_pkg::DIM_RESET;
    grid_rows           = hgt_pkg::DIM_RESET;
    cur_idx             = '0;
    start_idx           = '0;
    touring             = 1'b0;
    build_curve();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_advance();
    test_full_grid_corners();
    test_outside_start();
    test_single_point();
    test_empty_and_oversized();
    test_tour_wrap_end();
    test_grid_change();
    test_random_tours(ITEM_GOAL - 130);
    test_steady_stream(ITEM_GOAL + 26);

    repeat (600) @(posedge clk);
    $display("Sent %0d requests, %0d tours started, %0d register writes.",
             items_sent, tours_started, reg_writes);
    $display("Checked %0d emitted grid points, %0d mismatches.", points_seen, mismatches);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("hilbert_grid_tour_tb OK");
    end else begin
      $display("hilbert_grid_tour_tb NOT OK");
    end
    $finish;
  end

endmodule
